// ===== rtl/sacl_pkg.sv =====
// Shared types and constants for the set-associative cache LRU lookup.
`timescale 1ns / 1ps
`default_nettype none
package sacl_pkg;

	// fixed widths of the result fields
	localparam int unsigned CNT_W     = 32;
	localparam int unsigned TAG_OUT_W = 22;
	localparam int unsigned SET_OUT_W = 6;
	localparam int unsigned OFF_OUT_W = 4;
	localparam int unsigned WAY_OUT_W = 2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} sacl_state_t;

	// sequencer to compare unit
	typedef struct packed {
		logic step;
		logic first;
	} sacl_cmp_ctl_t;

	// compare unit status back to the sequencer
	typedef struct packed {
		logic hit;
		logic victim_valid;
	} sacl_cmp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/set_assoc_cache_lru_lookup.sv =====
// Top level: set-associative cache tag lookup with LRU replacement.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Input: drive address and pulse start; the word is taken at a clock edge
//   where start is high and busy is low.
//   Output: one result per access, shown for exactly one cycle with done high.
//   The receiver cannot stall; results must be taken in that cycle.
// Sequence:
//   The ways of the set are read one per cycle from the line store's read port
//   and checked by one shared compare unit, then the chosen way is written.
//   done is registered from the write state; busy stays high through the
//   scan and write states, so a new access is taken only once the last one
//   is written, and it can be taken while done is high.
// Reset:
//   arst_n clears counters and the sequencer. Then a clearing pass writes zero
//   to every one of the NUM_SETS*NUM_WAYS lines (256 by default), with busy high.
//   Stamps saturate at all ones; hit and miss counts wrap.
module set_assoc_cache_lru_lookup #(
	parameter int unsigned NUM_SETS    = 64,
	parameter int unsigned NUM_WAYS    = 4,
	parameter int unsigned BLOCK_WORDS = 16,
	parameter int unsigned ADDR_BITS   = 32,
	parameter int unsigned STAMP_BITS  = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [ADDR_BITS-1:0]              address,
	output logic                                   done,
	output logic                                   hit,
	output logic [sacl_pkg::CNT_W-1:0]             access_number,
	output logic [sacl_pkg::TAG_OUT_W-1:0]         tag,
	output logic [sacl_pkg::SET_OUT_W-1:0]         set_index,
	output logic [sacl_pkg::OFF_OUT_W-1:0]         word_offset,
	output logic [sacl_pkg::WAY_OUT_W-1:0]         way,
	output logic                                   victim_valid,
	output logic [sacl_pkg::TAG_OUT_W-1:0]         victim_tag,
	output logic [sacl_pkg::CNT_W-1:0]             hits_so_far,
	output logic [sacl_pkg::CNT_W-1:0]             misses_so_far
);

	// floor(log2(x)) = clog2(x+1)-1
	localparam int OFF_BITS = $clog2(BLOCK_WORDS + 1) - 1;
	localparam int SET_BITS = $clog2(NUM_SETS + 1) - 1;
	localparam int TAG_BITS = int'(ADDR_BITS) - OFF_BITS - SET_BITS;
	localparam int OFF_W    = (OFF_BITS > 0) ? OFF_BITS : 1;
	localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int TAG_W    = (TAG_BITS > 0) ? TAG_BITS : 1;
	localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int LINES    = NUM_SETS * NUM_WAYS;
	localparam int LINE_W   = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int LA_W     = SET_W + WAY_W + 1;
	localparam int DATA_W   = 1 + TAG_W + int'(STAMP_BITS);

	localparam logic [WAY_W-1:0]      LAST_WAY  = WAY_W'(NUM_WAYS - 1);
	localparam logic [LINE_W-1:0]     LAST_LINE = LINE_W'(LINES - 1);
	localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

	sacl_pkg::sacl_state_t    state_q, state_d;
	sacl_pkg::sacl_cmp_ctl_t  cmp_ctl;
	sacl_pkg::sacl_cmp_stat_t cmp_stat;

	logic [TAG_W-1:0]      in_tag, tag_q;
	logic [SET_W-1:0]      in_set, set_q;
	logic [OFF_W-1:0]      in_off, off_q;
	logic [WAY_W-1:0]      way_q;
	logic [LINE_W-1:0]     clr_q;
	logic [STAMP_BITS-1:0] acc_q;
	logic [sacl_pkg::CNT_W-1:0] hit_cnt_q, miss_cnt_q;
	logic                  done_q;

	logic                  accept;
	logic                  last_way;
	logic                  rd_en, wr_en;
	logic [SET_W-1:0]      rd_set;
	logic [WAY_W-1:0]      rd_way;
	logic [LINE_W-1:0]     rd_line, wr_line;
	logic [DATA_W-1:0]     rd_data, wr_data;
	logic                  rd_valid;
	logic [TAG_W-1:0]      rd_tag;
	logic [STAMP_BITS-1:0] rd_stamp;
	logic [WAY_W-1:0]      cmp_way;
	logic [TAG_W-1:0]      cmp_vtag;

	// address split
	assign in_off = (OFF_BITS > 0) ? address[OFF_W-1:0] : '0;
	assign in_set = (SET_BITS > 0) ? SET_W'(address >> OFF_BITS) : '0;
	assign in_tag = (TAG_BITS > 0) ? TAG_W'(address >> (OFF_BITS + SET_BITS)) : '0;

	assign accept   = start && (state_q == sacl_pkg::ST_IDLE);
	assign last_way = (way_q == LAST_WAY);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sacl_pkg::ST_CLEAR: if (clr_q == LAST_LINE) state_d = sacl_pkg::ST_IDLE;
			sacl_pkg::ST_IDLE:  if (start) state_d = sacl_pkg::ST_SCAN;
			sacl_pkg::ST_SCAN:  if (last_way) state_d = sacl_pkg::ST_WRITE;
			sacl_pkg::ST_WRITE: state_d = sacl_pkg::ST_IDLE;
			default:            state_d = sacl_pkg::ST_CLEAR;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy          = 1'b1;
		rd_en         = 1'b0;
		wr_en         = 1'b0;
		cmp_ctl.step  = 1'b0;
		cmp_ctl.first = (way_q == '0);
		unique case (state_q)
			sacl_pkg::ST_CLEAR: wr_en = 1'b1;
			sacl_pkg::ST_IDLE: begin
				busy  = 1'b0;
				rd_en = start;
			end
			sacl_pkg::ST_SCAN: begin
				cmp_ctl.step = 1'b1;
				rd_en        = !last_way;
			end
			sacl_pkg::ST_WRITE: wr_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sacl_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control counters and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			way_q      <= '0;
			acc_q      <= '0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= (state_q == sacl_pkg::ST_WRITE);
			if (state_q == sacl_pkg::ST_CLEAR) begin
				clr_q <= clr_q + LINE_W'(1);
			end
			if (accept) begin
				way_q <= '0;
				if (acc_q != STAMP_MAX) begin
					acc_q <= acc_q + STAMP_BITS'(1);
				end
			end else if (state_q == sacl_pkg::ST_SCAN && !last_way) begin
				way_q <= way_q + WAY_W'(1);
			end
			if (state_q == sacl_pkg::ST_WRITE) begin
				if (cmp_stat.hit) begin
					hit_cnt_q <= hit_cnt_q + sacl_pkg::CNT_W'(1);
				end else begin
					miss_cnt_q <= miss_cnt_q + sacl_pkg::CNT_W'(1);
				end
			end
		end
	end

	// access word, held for the result
	always_ff @(posedge clk) begin
		if (accept) begin
			tag_q <= in_tag;
			set_q <= in_set;
			off_q <= in_off;
		end
	end

	// line addressing: set * NUM_WAYS + way
	assign rd_set  = (state_q == sacl_pkg::ST_IDLE) ? in_set : set_q;
	assign rd_way  = (state_q == sacl_pkg::ST_IDLE) ? '0 : way_q + WAY_W'(1);
	assign rd_line = LINE_W'(LA_W'(rd_set) * LA_W'(NUM_WAYS) + LA_W'(rd_way));
	assign wr_line = (state_q == sacl_pkg::ST_CLEAR) ? clr_q :
		LINE_W'(LA_W'(set_q) * LA_W'(NUM_WAYS) + LA_W'(cmp_way));
	assign wr_data = (state_q == sacl_pkg::ST_CLEAR) ? '0 : {1'b1, tag_q, acc_q};

	sacl_line_ram #(
		.DEPTH  (LINES),
		.ADDR_W (LINE_W),
		.DATA_W (DATA_W)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_line),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_line),
		.rd_data (rd_data)
	);

	assign {rd_valid, rd_tag, rd_stamp} = rd_data;

	sacl_way_cmp #(
		.TAG_W   (TAG_W),
		.STAMP_W (STAMP_BITS),
		.WAY_W   (WAY_W)
	) u_way_cmp (
		.clk        (clk),
		.ctl        (cmp_ctl),
		.way_idx    (way_q),
		.lookup_tag (tag_q),
		.line_valid (rd_valid),
		.line_tag   (rd_tag),
		.line_stamp (rd_stamp),
		.stat       (cmp_stat),
		.sel_way    (cmp_way),
		.victim_tag (cmp_vtag)
	);

	assign done          = done_q;
	assign hit           = cmp_stat.hit;
	assign access_number = sacl_pkg::CNT_W'(acc_q);
	assign tag           = sacl_pkg::TAG_OUT_W'(tag_q);
	assign set_index     = sacl_pkg::SET_OUT_W'(set_q);
	assign word_offset   = sacl_pkg::OFF_OUT_W'(off_q);
	assign way           = sacl_pkg::WAY_OUT_W'(cmp_way);
	assign victim_valid  = cmp_stat.victim_valid;
	assign victim_tag    = sacl_pkg::TAG_OUT_W'(cmp_vtag);
	assign hits_so_far   = hit_cnt_q;
	assign misses_so_far = miss_cnt_q;

`ifndef SYNTHESIS
	a_done_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == sacl_pkg::ST_WRITE))
		else $error("result word without a line update");

	a_busy_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sacl_pkg::ST_CLEAR) |-> busy)
		else $error("accepting words during clearing pass");

	a_accept_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == sacl_pkg::ST_SCAN && way_q == '0))
		else $error("accepted word did not start a way scan");

	a_hit_no_victim: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && victim_valid))
		else $error("hit reported with a write-back victim");

	a_one_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((hits_so_far != $past(hits_so_far, 2)) !=
			(misses_so_far != $past(misses_so_far, 2))))
		else $error("hit and miss counts did not advance by exactly one");
`endif

endmodule
`default_nettype wire

// ===== rtl/sacl_line_ram.sv =====
// Line store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module sacl_line_ram #(
	parameter int unsigned DEPTH  = 256,
	parameter int unsigned ADDR_W = 8,
	parameter int unsigned DATA_W = 55
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sacl_way_cmp.sv =====
// Shared per-way compare unit: tag match and least-stamp victim tracking.
`timescale 1ns / 1ps
`default_nettype none
module sacl_way_cmp #(
	parameter int unsigned TAG_W   = 22,
	parameter int unsigned STAMP_W = 32,
	parameter int unsigned WAY_W   = 2
) (
	input  wire logic                   clk,
	input  wire sacl_pkg::sacl_cmp_ctl_t ctl,
	input  wire logic [WAY_W-1:0]       way_idx,
	input  wire logic [TAG_W-1:0]       lookup_tag,
	input  wire logic                   line_valid,
	input  wire logic [TAG_W-1:0]       line_tag,
	input  wire logic [STAMP_W-1:0]     line_stamp,
	output sacl_pkg::sacl_cmp_stat_t    stat,
	output logic      [WAY_W-1:0]       sel_way,
	output logic      [TAG_W-1:0]       victim_tag
);

	logic               match;
	logic               older;
	logic               hit_q;
	logic [WAY_W-1:0]   hit_way_q;
	logic [STAMP_W-1:0] best_q;
	logic [WAY_W-1:0]   vic_way_q;
	logic               vic_valid_q;
	logic [TAG_W-1:0]   vic_tag_q;

	assign match = line_valid && (line_tag == lookup_tag);
	assign older = line_stamp < best_q;

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			if (ctl.first || (!hit_q && match)) begin
				hit_q     <= match;
				hit_way_q <= way_idx;
			end
			// strict less-than keeps the lowest way on ties
			if (ctl.first || older) begin
				best_q      <= line_stamp;
				vic_way_q   <= way_idx;
				vic_valid_q <= line_valid;
				vic_tag_q   <= line_tag;
			end
		end
	end

	assign stat.hit          = hit_q;
	assign stat.victim_valid = !hit_q && vic_valid_q;
	assign sel_way           = hit_q ? hit_way_q : vic_way_q;
	assign victim_tag        = (!hit_q && vic_valid_q) ? vic_tag_q : '0;

endmodule
`default_nettype wire

// ===== bench/tb_set_assoc_cache_lru_lookup.sv =====
// Testbench for the set-associative cache LRU lookup: directed and random accesses vs. a predictor.
`timescale 1ns / 1ps
module tb_set_assoc_cache_lru_lookup;

	localparam int unsigned CNT_W     = sacl_pkg::CNT_W;
	localparam int unsigned TAG_OUT_W = sacl_pkg::TAG_OUT_W;
	localparam int unsigned SET_OUT_W = sacl_pkg::SET_OUT_W;
	localparam int unsigned OFF_OUT_W = sacl_pkg::OFF_OUT_W;
	localparam int unsigned WAY_OUT_W = sacl_pkg::WAY_OUT_W;

	localparam int unsigned SETS      = 64;
	localparam int unsigned WAYS      = 4;
	localparam int unsigned OFF_BITS  = 4;
	localparam int unsigned SET_BITS  = 6;
	localparam int unsigned PHASE_LEN = 100;
	localparam int unsigned SETTLE    = 20;
	localparam int unsigned LIMIT_NS  = 3_600_000;
	localparam int unsigned MAX_PRINT = 40;

	typedef struct {
		logic [31:0] address;
		int unsigned idle_pct;
		bit          drain;
	} access_req_t;

	typedef struct {
		logic                 hit;
		logic [CNT_W-1:0]     access_number;
		logic [TAG_OUT_W-1:0] tag;
		logic [SET_OUT_W-1:0] set_index;
		logic [OFF_OUT_W-1:0] word_offset;
		logic [WAY_OUT_W-1:0] way;
		logic                 victim_valid;
		logic [TAG_OUT_W-1:0] victim_tag;
		logic [CNT_W-1:0]     hits_so_far;
		logic [CNT_W-1:0]     misses_so_far;
	} lookup_res_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [31:0]          address;
	logic                 done;
	logic                 hit;
	logic [CNT_W-1:0]     access_number;
	logic [TAG_OUT_W-1:0] tag;
	logic [SET_OUT_W-1:0] set_index;
	logic [OFF_OUT_W-1:0] word_offset;
	logic [WAY_OUT_W-1:0] way;
	logic                 victim_valid;
	logic [TAG_OUT_W-1:0] victim_tag;
	logic [CNT_W-1:0]     hits_so_far;
	logic [CNT_W-1:0]     misses_so_far;

	set_assoc_cache_lru_lookup dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.address       (address),
		.done          (done),
		.hit           (hit),
		.access_number (access_number),
		.tag           (tag),
		.set_index     (set_index),
		.word_offset   (word_offset),
		.way           (way),
		.victim_valid  (victim_valid),
		.victim_tag    (victim_tag),
		.hits_so_far   (hits_so_far),
		.misses_so_far (misses_so_far)
	);

	// predictor state
	logic [TAG_OUT_W-1:0] line_tag   [SETS][WAYS];
	bit                   line_vld   [SETS][WAYS];
	logic [CNT_W-1:0]     line_stamp [SETS][WAYS];
	logic [CNT_W-1:0]     stamp_cnt;
	logic [CNT_W-1:0]     hit_cnt;
	logic [CNT_W-1:0]     miss_cnt;

	access_req_t          address_queue[$];
	lookup_res_t          expected_lookups[$];
	logic [TAG_OUT_W-1:0] tag_pool[8];

	bit          word_taken = 1'b0;
	int unsigned n_items    = 0;
	int unsigned n_accepted = 0;
	int unsigned n_errors   = 0;
	int unsigned n_hits     = 0;
	int unsigned n_misses   = 0;
	int unsigned n_wbacks   = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic lookup_res_t cache_lookup(input logic [31:0] a);
		lookup_res_t r;
		logic [TAG_OUT_W-1:0] t;
		int unsigned s;
		int unsigned v;
		bit found;
		t = a[31:OFF_BITS+SET_BITS];
		s = 32'(a[OFF_BITS +: SET_BITS]);
		found = 1'b0;
		v = 0;
		if (stamp_cnt != '1)
			stamp_cnt = stamp_cnt + CNT_W'(1);
		for (int w = 0; w < WAYS; w++) begin
			if (!found && line_vld[s][w] && line_tag[s][w] == t) begin
				found = 1'b1;
				v = w;
			end
		end
		r.victim_valid = 1'b0;
		r.victim_tag = '0;
		if (found) begin
			hit_cnt = hit_cnt + CNT_W'(1);
		end else begin
			// oldest stamp wins, lowest way on a tie; invalid lines keep stamp 0
			for (int w = 1; w < WAYS; w++)
				if (line_stamp[s][w] < line_stamp[s][v])
					v = w;
			if (line_vld[s][v]) begin
				r.victim_valid = 1'b1;
				r.victim_tag = line_tag[s][v];
			end
			line_tag[s][v] = t;
			line_vld[s][v] = 1'b1;
			miss_cnt = miss_cnt + CNT_W'(1);
		end
		line_stamp[s][v] = stamp_cnt;
		r.hit = found;
		r.access_number = stamp_cnt;
		r.tag = t;
		r.set_index = SET_OUT_W'(s);
		r.word_offset = a[OFF_BITS-1:0];
		r.way = WAY_OUT_W'(v);
		r.hits_so_far = hit_cnt;
		r.misses_so_far = miss_cnt;
		return r;
	endfunction

	function automatic logic [31:0] make_addr(input logic [TAG_OUT_W-1:0] t,
			input logic [SET_BITS-1:0] s, input logic [OFF_BITS-1:0] o);
		return {t, s, o};
	endfunction

	// mostly a few hot sets and a small tag pool, so hits and evictions are common
	function automatic logic [31:0] rand_address();
		logic [SET_BITS-1:0] s;
		if ($urandom_range(99) < 15)
			return $urandom();
		s = SET_BITS'(($urandom_range(99) < 70) ? $urandom_range(3) :
			$urandom_range(SETS - 1));
		return make_addr(tag_pool[$urandom_range(7)], s, OFF_BITS'($urandom_range(15)));
	endfunction

	task automatic report_mismatch(input string msg);
		n_errors++;
		if (n_errors <= MAX_PRINT)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s: got %h, expected %h (lookup %0d)",
				name, got, want, n_hits + n_misses));
	endtask

	task automatic add_item(input logic [31:0] a, input int unsigned idle_pct, input bit drain);
		access_req_t req;
		req.address = a;
		req.idle_pct = idle_pct;
		req.drain = drain;
		address_queue = {address_queue, req};
		n_items++;
	endtask

	// driver: one word per handshake, new values at the falling edge
	always @(negedge clk) begin : driver
		access_req_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || word_taken) begin
			if (address_queue.size() != 0
					&& !(address_queue[0].drain && expected_lookups.size() != 0)
					&& $urandom_range(99) >= address_queue[0].idle_pct) begin
				nxt = address_queue.pop_front();
				start <= 1'b1;
				address <= nxt.address;
			end else begin
				start <= 1'b0;
				address <= $urandom();
			end
		end
	end

	// monitor: check results first, then predict the word taken at this edge
	always @(posedge clk) begin : monitor
		lookup_res_t want;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (expected_lookups.size() == 0) begin
					report_mismatch("result strobe with no lookup pending");
				end else begin
					want = expected_lookups.pop_front();
					check_field("hit", 32'(hit), 32'(want.hit));
					check_field("access_number", access_number, want.access_number);
					check_field("tag", 32'(tag), 32'(want.tag));
					check_field("set_index", 32'(set_index), 32'(want.set_index));
					check_field("word_offset", 32'(word_offset), 32'(want.word_offset));
					check_field("way", 32'(way), 32'(want.way));
					check_field("victim_valid", 32'(victim_valid), 32'(want.victim_valid));
					check_field("victim_tag", 32'(victim_tag), 32'(want.victim_tag));
					check_field("hits_so_far", hits_so_far, want.hits_so_far);
					check_field("misses_so_far", misses_so_far, want.misses_so_far);
					if (want.hit)
						n_hits++;
					else
						n_misses++;
					if (want.victim_valid)
						n_wbacks++;
				end
			end
			if (start && !busy) begin
				expected_lookups = {expected_lookups, cache_lookup(address)};
				n_accepted++;
			end
			word_taken <= start && !busy;
		end
	end

	initial begin : limit
		#(LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		int unsigned idle_by_phase[4];
		arst_n = 1'b0;
		start = 1'b0;
		address = '0;
		for (int s = 0; s < SETS; s++) begin
			for (int w = 0; w < WAYS; w++) begin
				line_tag[s][w] = '0;
				line_vld[s][w] = 1'b0;
				line_stamp[s][w] = '0;
			end
		end
		stamp_cnt = '0;
		hit_cnt = '0;
		miss_cnt = '0;
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			tag_pool[i] = TAG_OUT_W'($urandom());
		idle_by_phase = '{0, 85, 36, 0};

		// tag zero must not match the zeroed but invalid lines
		add_item(make_addr(22'h0, 6'd0, 4'd0), 0, 1'b0);
		add_item(make_addr(22'h0, 6'd0, 4'd15), 0, 1'b0);
		add_item(32'hFFFF_FFFF, 0, 1'b0);
		add_item(32'hFFFF_FFF0, 0, 1'b0);
		add_item(32'hAAAA_AAAA, 0, 1'b0);
		add_item(32'h5555_5555, 0, 1'b0);
		// fill one set, then walk the LRU order through write-backs
		for (int i = 1; i <= 4; i++)
			add_item(make_addr(TAG_OUT_W'(i), 6'd9, OFF_BITS'(i)), 0, 1'b0);
		add_item(make_addr(22'h1, 6'd9, 4'd3), 0, 1'b0);
		add_item(make_addr(22'h5, 6'd9, 4'd0), 0, 1'b0);
		add_item(make_addr(22'h2, 6'd9, 4'd8), 0, 1'b0);
		add_item(make_addr(22'h4, 6'd9, 4'd1), 0, 1'b0);
		add_item(make_addr(22'h3FFFFF, 6'd9, 4'd15), 0, 1'b0);
		add_item(make_addr(22'h0, 6'd0, 4'd7), 0, 1'b0);
		add_item(make_addr(22'h3FFFFF, 6'd0, 4'd0), 0, 1'b0);
		add_item(make_addr(22'h2AAAAA, 6'd63, 4'd5), 0, 1'b0);
		add_item(make_addr(22'h155555, 6'd63, 4'd10), 0, 1'b0);

		// each phase opens by letting the pipeline drain
		for (int p = 0; p < 4; p++)
			for (int i = 0; i < PHASE_LEN; i++)
				add_item(rand_address(), idle_by_phase[p], i == 0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (n_accepted < n_items || expected_lookups.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Ran %0d lookups: %0d hits, %0d misses, %0d write-backs,", n_items,
			n_hits, n_misses, n_wbacks);
		$display("across idle-free and heavily gapped sender phases; %0d mismatches.",
			n_errors);
		if (n_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/sacl_pkg.sv
rtl/sacl_line_ram.sv
rtl/sacl_way_cmp.sv
rtl/set_assoc_cache_lru_lookup.sv
bench/tb_set_assoc_cache_lru_lookup.sv
